FILE: rtl/core/alwc_pkg.sv
// Package: opcode, status and cell control types for the array list core.
package alwc_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FIRST  = 2'd1,
    OP_NEXT   = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_FULL          = 2'd1,
    ST_NONE_TO_VISIT = 2'd2,
    ST_NO_CURRENT    = 2'd3
  } status_t;

  typedef struct packed {
    logic append_ok;
    logic remove_ok;
  } cell_ctrl_t;

endpackage : alwc_pkg

FILE: rtl/core/alwc_cell.sv
// Entry cell: holds one list entry, loads on append, takes its upper neighbor on a removal at or below its index.
module alwc_cell #(
  parameter int IDX        = 0,
  parameter int IW         = 6,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  alwc_pkg::cell_ctrl_t   ctrl,
  input  logic [IW-1:0]          wr_idx,
  input  logic [IW-1:0]          shift_idx,
  input  logic [IW-1:0]          rd_idx,
  input  logic [DATA_WIDTH-1:0]  wr_data,
  input  logic [DATA_WIDTH-1:0]  nbr_data,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic [DATA_WIDTH-1:0]  sel_data_o
);
  import alwc_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.append_ok && (wr_idx == MY_IDX)) begin
      data_nxt = wr_data;
    end else if (ctrl.remove_ok && (MY_IDX >= shift_idx)) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o     = data_r;
  assign sel_data_o = (rd_idx == MY_IDX) ? data_r : '0;

endmodule : alwc_cell

FILE: rtl/core/array_list_with_cursor_core.sv
// Top level: fixed-capacity ordered list with an iteration cursor.
// Usage:
//   Input channel in_*: one transaction per operation; in_tuser carries the
//   opcode (append, go to first, go to next, remove current), in_tdata the
//   value to append. Output channel out_*: exactly one result transaction per
//   operation, with the status in out_tuser and the read value and entry count
//   in out_tdata.
//   Result: registered, it appears in the cycle after the operation is accepted.
//   Throughput: one operation per cycle while out_tready is high. Every entry
//   lives in its own cell of a row; on removal all cells at or above the cursor
//   load their upper neighbor in the same cycle, and reads select one cell
//   through a one-hot AND-OR.
//   Reset: count cleared, cursor set to none, no result pending; entry cells
//   are not cleared (only entries below the count are ever read).
//   Stall: the result is held in an output register; while it waits and
//   out_tready is low, in_tready is low. When out_tready is high, a new
//   operation is taken in the same cycle the held result leaves.
module array_list_with_cursor_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [38:32] entry_count, [39] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import alwc_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [CW-1:0]        count_r, count_nxt;
  logic signed [IW:0]   cursor_r, cursor_nxt;
  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  logic [31:0]          rd_value_r;
  logic [CW-1:0]        out_count_r;

  logic                 in_fire;
  opcode_t              opcode;
  cell_ctrl_t           ctrl;
  logic signed [SW-1:0] cur_s, cnt_s;
  logic                 full, next_none, rem_ok, rd_en;
  logic [IW-1:0]        rd_idx, wr_idx, shift_idx;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_sel  [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_mux;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign opcode    = opcode_t'(in_tuser);

  assign cur_s     = SW'(cursor_r);
  assign cnt_s     = $signed({1'b0, count_r});
  assign full      = (count_r == CAP_CNT);
  assign next_none = (cur_s >= (cnt_s - SW'(1)));
  assign rem_ok    = (cur_s >= SW'(0)) && (cur_s < cnt_s);
  assign wr_idx    = IW'(count_r);
  assign shift_idx = IW'(cursor_r);
  assign wr_data   = DATA_WIDTH'(in_tdata);

  always_comb begin
    ctrl       = '0;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    rd_idx     = '0;
    rd_en      = 1'b0;
    case (opcode)
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.append_ok = in_fire;
          count_nxt      = count_r + CW'(1);
        end
      end
      OP_FIRST: begin
        if (count_r == '0) begin
          status_nxt = ST_NONE_TO_VISIT;
        end else begin
          cursor_nxt = '0;
          rd_en      = 1'b1;
        end
      end
      OP_NEXT: begin
        if (next_none) begin
          status_nxt = ST_NONE_TO_VISIT;
        end else begin
          cursor_nxt = cursor_r + (IW+1)'(1);
          rd_idx     = IW'(cursor_nxt);
          rd_en      = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!rem_ok) begin
          status_nxt = ST_NO_CURRENT;
        end else begin
          ctrl.remove_ok = in_fire;
          count_nxt      = count_r - CW'(1);
          cursor_nxt     = cursor_r - (IW+1)'(1);
          rd_idx         = IW'(cursor_r);
          rd_en          = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] nbr;
    if (g == CAPACITY - 1) begin : g_last
      assign nbr = cell_data[g];
    end else begin : g_mid
      assign nbr = cell_data[g+1];
    end
    alwc_cell #(
      .IDX        (g),
      .IW         (IW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_idx     (wr_idx),
      .shift_idx  (shift_idx),
      .rd_idx     (rd_idx),
      .wr_data    (wr_data),
      .nbr_data   (nbr),
      .data_o     (cell_data[g]),
      .sel_data_o (cell_sel[g])
    );
  end

  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_mux = rd_mux | cell_sel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r    <= status_nxt;
      rd_value_r  <= rd_en ? 32'(rd_mux) : 32'd0;
      out_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, 7'(out_count_r), rd_value_r};

endmodule : array_list_with_cursor_core

FILE: sim/tb.sv
// Testbench for array_list_with_cursor_core: directed and random list operations.
`timescale 1ns / 100ps

module tb;
  import alwc_pkg::*;

  localparam int CAP        = 64;
  localparam int DW         = 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t     status;
    logic [31:0] read_value;
    logic [6:0]  entry_count;
  } list_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic [1:0]  in_tuser;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] read_value, [38:32] entry_count, [39] zero
  logic [1:0]  out_tuser;  // [1:0] status

  array_list_with_cursor_core #(
    .CAPACITY   (CAP),
    .DATA_WIDTH (DW)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // list predictor state
  logic [31:0] list_mem [CAP];
  int          list_count;
  int          list_cursor;
  int          peak_count;

  list_result_t pending_results[$];

  int err_count;
  int ops_sent;
  int results_seen;
  int status_hits [4];
  int cycle_count;
  int burst_left;
  int rx_mode;
  int rx_phase_left;
  int rx_tick;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic list_result_t apply_list_op(opcode_t op, logic [31:0] val);
    list_result_t r;
    int i;
    r.status     = ST_OK;
    r.read_value = '0;
    case (op)
      OP_APPEND: begin
        if (list_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_count] = val;
          list_count++;
        end
      end
      OP_FIRST: begin
        if (list_count <= 0) begin
          r.status = ST_NONE_TO_VISIT;
        end else begin
          list_cursor  = 0;
          r.read_value = list_mem[0];
        end
      end
      OP_NEXT: begin
        if (list_cursor >= list_count - 1) begin
          r.status = ST_NONE_TO_VISIT;
        end else begin
          list_cursor++;
          r.read_value = list_mem[list_cursor];
        end
      end
      default: begin
        if (list_cursor < 0 || list_cursor >= list_count) begin
          r.status = ST_NO_CURRENT;
        end else begin
          r.read_value = list_mem[list_cursor];
          for (i = list_cursor; i < list_count - 1; i++) list_mem[i] = list_mem[i + 1];
          list_count--;
          list_cursor--;
        end
      end
    endcase
    r.entry_count = 7'(list_count);
    return r;
  endfunction

  // one transaction on the input channel; called at a falling edge
  task automatic send_op(input opcode_t op, input logic [31:0] val);
    list_result_t exp_r;
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_r = apply_list_op(op, val);
    pending_results.push_back(exp_r);
    ops_sent++;
    if (list_count > peak_count) peak_count = list_count;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(20, 10) : $urandom_range(5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(16, 1);
    end
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(15))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = 32'h0000_0000;
      3:       v = 32'hffff_ffff;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_empty_list();
    send_op(OP_FIRST, $urandom);
    send_op(OP_NEXT, $urandom);
    send_op(OP_REMOVE, $urandom);
  endtask

  task automatic test_edge_values();
    send_op(OP_APPEND, 32'h8000_0000);
    send_op(OP_APPEND, 32'h7fff_ffff);
    send_op(OP_APPEND, 32'h0000_0000);
    send_op(OP_APPEND, 32'hffff_ffff);
    send_op(OP_NEXT, $urandom);            // no cursor: visits entry 0
    send_op(OP_NEXT, $urandom);
    send_op(OP_FIRST, $urandom);
    send_op(OP_REMOVE, $urandom);          // entry 0: cursor back to none
    send_op(OP_NEXT, $urandom);            // new entry 0
    send_op(OP_NEXT, $urandom);
    send_op(OP_REMOVE, $urandom);          // middle entry
    send_op(OP_NEXT, $urandom);            // onto last
    send_op(OP_NEXT, $urandom);            // past the end
    send_op(OP_REMOVE, $urandom);          // last entry
    send_op(OP_REMOVE, $urandom);
    send_op(OP_REMOVE, $urandom);          // no current entry
    send_op(OP_NEXT, $urandom);
    send_op(OP_APPEND, 32'h5555_5555);
    send_op(OP_APPEND, 32'haaaa_aaaa);
    send_op(OP_FIRST, $urandom);
    send_op(OP_NEXT, $urandom);
  endtask

  task automatic test_fill_to_full();
    while (list_count < CAP) send_op(OP_APPEND, pick_value());
    send_op(OP_APPEND, pick_value());
    send_op(OP_APPEND, pick_value());
    send_op(OP_FIRST, $urandom);
    while (list_cursor < list_count - 1) send_op(OP_NEXT, $urandom);
    send_op(OP_NEXT, $urandom);
    send_op(OP_REMOVE, $urandom);
    send_op(OP_APPEND, pick_value());
    send_op(OP_APPEND, pick_value());
  endtask

  task automatic test_drain();
    send_op(OP_FIRST, $urandom);
    while (list_count > 0) begin
      send_op(OP_REMOVE, $urandom);
      if ($urandom_range(3) == 0) send_op(OP_FIRST, $urandom);
      else send_op(OP_NEXT, $urandom);
    end
    send_op(OP_REMOVE, $urandom);
  endtask

  task automatic test_random_walk(input int n_ops);
    int w_app;
    int w_first;
    int w_next;
    int phase_left;
    int roll;
    opcode_t op;
    phase_left = 0;
    w_app = 25;
    w_first = 25;
    w_next = 25;
    repeat (n_ops) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(120, 40);
        case ($urandom_range(3))
          0: begin w_app = 55; w_first = 10; w_next = 20; end
          1: begin w_app = 15; w_first = 15; w_next = 30; end
          2: begin w_app = 20; w_first = 15; w_next = 45; end
          default: begin w_app = 25; w_first = 25; w_next = 25; end
        endcase
      end
      phase_left--;
      roll = $urandom_range(99);
      if (roll < w_app) op = OP_APPEND;
      else if (roll < w_app + w_first) op = OP_FIRST;
      else if (roll < w_app + w_first + w_next) op = OP_NEXT;
      else op = OP_REMOVE;
      send_op(op, pick_value());
    end
  endtask

  // result checker
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      status_hits[out_tuser]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d data %h", out_tuser, out_tdata);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_tuser);
          err_count++;
        end
        if (out_tdata[31:0] !== exp_r.read_value) begin
          $error("read_value: expected %h, actual %h", exp_r.read_value, out_tdata[31:0]);
          err_count++;
        end
        if (out_tdata[38:32] !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", exp_r.entry_count,
                 out_tdata[38:32]);
          err_count++;
        end
        if (out_tdata[39] !== 1'b0) begin
          $error("pad bit: expected 0, actual %b", out_tdata[39]);
          err_count++;
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = $urandom_range(3);
      rx_phase_left = $urandom_range(200, 20);
    end else begin
      rx_phase_left--;
    end
    rx_tick++;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(9) < 7);
      2:       out_tready <= (rx_tick % 4 == 0);
      default: out_tready <= ($urandom_range(9) < 3);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = OP_APPEND;
    out_tready    = 1'b0;
    list_count    = 0;
    list_cursor   = -1;
    peak_count    = 0;
    err_count     = 0;
    ops_sent      = 0;
    results_seen  = 0;
    status_hits   = '{default: 0};
    cycle_count   = 0;
    burst_left    = 1;
    rx_mode       = 0;
    rx_phase_left = 0;
    rx_tick       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_list();
    test_edge_values();
    test_fill_to_full();
    test_drain();
    test_random_walk(1160);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_count++;
    end

    $display("Checked %0d results for %0d list operations; peak entry count %0d of %0d.",
             results_seen, ops_sent, peak_count, CAP);
    $display("Status mix ok/full/nothing to visit/no current: %0d/%0d/%0d/%0d.",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_NONE_TO_VISIT],
             status_hits[ST_NO_CURRENT]);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
